### hw/rtl/oppc_pkg.sv
// Shared constants and codes for the outline pair proximity check.
`timescale 1ns / 1ps
`default_nettype none

package oppc_pkg;

    // Default sizes handed to the top level
    localparam int DEF_MAX_OUTLINE_POINTS = 256;
    localparam int DEF_MAX_PIXELS         = 524288;

    // Coordinate and distance widths, fixed by the port list
    localparam int COORD_W = 16;
    localparam int POINT_W = 3 * COORD_W;
    localparam int MAG_W   = COORD_W + 1;
    localparam int DIST_W  = 2 * MAG_W;
    localparam int LIM_W   = 16;
    localparam int LIMSQ_W = 2 * LIM_W;

    // Saturated closest distance: 3 * (2^COORD_W - 1)^2
    localparam logic [DIST_W-1:0] CLOSEST_SAT =
        DIST_W'(3) * DIST_W'((1 << COORD_W) - 1) * DIST_W'((1 << COORD_W) - 1);

    // Input commands
    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_MASK        = 2'd2;
    localparam logic [1:0] CMD_EVALUATE    = 2'd3;

    // Verdict codes
    localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
    localparam logic [2:0] VERDICT_LARGER   = 3'd1;
    localparam logic [2:0] VERDICT_OVERLAP  = 3'd2;
    localparam logic [2:0] VERDICT_CLOSEST  = 3'd3;
    localparam logic [2:0] VERDICT_FARTHEST = 3'd4;

    // Configuration register indexes
    localparam int           CFG_INDEX_W    = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LIMIT = 2'd1;
    localparam logic [LIM_W-1:0] MAX_LIMIT_RESET = 16'hFFFF;

endpackage

`default_nettype wire

### hw/rtl/outline_pair_proximity_check_core.sv
// Top level of the outline pair proximity check.
//
// Usage: words enter on the in channel (in_valid / in_ready) and carry a
// command. Load words store one outline point of the first or second region,
// mask words count one pixel's membership; a stream of them is taken one
// word per cycle while the block is idle. An evaluate word squares the two
// limits, then walks every pair of stored points with one shared 17x17
// squarer, three components per pair. in_ready is low during that walk
// and rises again as the result word is offered. The result word waits in an
// output register on the out channel (out_valid / out_ready); load and mask
// words are still taken while it waits, and a following evaluate holds in
// its last step until the register is free. Evaluate clears counts, areas
// and flags. Limits are to be written on the cfg channel (always ready) only
// while the block is idle; the block itself does not enforce this. Reset
// clears counts, flags and limits (max limit to 65535); the point memories
// are not cleared and only stored entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module outline_pair_proximity_check_core
    import oppc_pkg::*;
#(
    parameter int MAX_OUTLINE_POINTS = DEF_MAX_OUTLINE_POINTS,
    parameter int MAX_PIXELS         = DEF_MAX_PIXELS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LIM_W-1:0]       cfg_data,
    // input words
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             command,
    input  wire logic [COORD_W-1:0]     x_mm,
    input  wire logic [COORD_W-1:0]     y_mm,
    input  wire logic [COORD_W-1:0]     z_mm,
    input  wire logic                   in_first_mask,
    input  wire logic                   in_second_mask,
    // result words
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        can_connect,
    output logic [2:0]                  verdict,
    output logic [DIST_W-1:0]           closest_sq_mm,
    output logic [DIST_W-1:0]           farthest_sq_mm,
    output logic                        points_dropped
);

    localparam int IDX_W  = $clog2(MAX_OUTLINE_POINTS);
    localparam int CNT_W  = $clog2(MAX_OUTLINE_POINTS + 1);
    localparam int AREA_W = $clog2(MAX_PIXELS + 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_OUTLINE_POINTS);
    localparam logic [AREA_W-1:0] AREA_FULL = AREA_W'(MAX_PIXELS);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LIMA = 3'd1;
    localparam logic [2:0] S_LIMB = 3'd2;
    localparam logic [2:0] S_LIMC = 3'd3;
    localparam logic [2:0] S_ADDR = 3'd4;
    localparam logic [2:0] S_SQ   = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_VERD = 3'd7;

    // Control registers
    logic [2:0]        state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic [CNT_W-1:0]  first_cnt_reg, first_cnt_next;
    logic [CNT_W-1:0]  second_cnt_reg, second_cnt_next;
    logic [AREA_W-1:0] first_area_reg, first_area_next;
    logic [AREA_W-1:0] second_area_reg, second_area_next;
    logic              overlap_reg, overlap_next;
    logic              overflow_reg, overflow_next;
    logic [LIM_W-1:0]  min_lim_reg, min_lim_next;
    logic [LIM_W-1:0]  max_lim_reg, max_lim_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath registers
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [DIST_W-1:0]  prod_reg;
    logic [DIST_W-1:0]  acc_reg, acc_next;
    logic [DIST_W-1:0]  closest_reg, closest_next;
    logic [DIST_W-1:0]  farthest_reg, farthest_next;
    logic [LIMSQ_W-1:0] lim_min_sq_reg, lim_min_sq_next;
    logic [LIMSQ_W-1:0] lim_max_sq_reg, lim_max_sq_next;
    logic               can_connect_reg, can_connect_next;
    logic [2:0]         verdict_reg, verdict_next;
    logic [DIST_W-1:0]  out_closest_reg, out_closest_next;
    logic [DIST_W-1:0]  out_farthest_reg, out_farthest_next;
    logic               dropped_reg, dropped_next;

    logic               in_fire;
    logic [POINT_W-1:0] wr_point;
    logic               wr_first, wr_second;
    logic               rd_en;
    logic [POINT_W-1:0] rd_first, rd_second;
    logic [COORD_W-1:0] coord_a, coord_b;
    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]   mult_a;
    logic [2:0]         verdict_calc;
    logic               pair_last_j, pair_last_i;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign wr_point  = {z_mm, y_mm, x_mm};
    assign wr_first  = in_fire && (command == CMD_LOAD_FIRST) && (first_cnt_reg != CNT_FULL);
    assign wr_second = in_fire && (command == CMD_LOAD_SECOND) && (second_cnt_reg != CNT_FULL);
    assign rd_en     = (state_reg == S_ADDR);

    // Point stores
    oppc_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_OUTLINE_POINTS)
    ) u_first_ram (
        .clk     (clk),
        .wr_en   (wr_first),
        .wr_addr (first_cnt_reg[IDX_W-1:0]),
        .wr_data (wr_point),
        .rd_en   (rd_en),
        .rd_addr (j_reg[IDX_W-1:0]),
        .rd_data (rd_first)
    );

    oppc_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_OUTLINE_POINTS)
    ) u_second_ram (
        .clk     (clk),
        .wr_en   (wr_second),
        .wr_addr (second_cnt_reg[IDX_W-1:0]),
        .wr_data (wr_point),
        .rd_en   (rd_en),
        .rd_addr (i_reg[IDX_W-1:0]),
        .rd_data (rd_second)
    );

    // Pick the coordinate pair for the current component
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                coord_a = rd_second[0 +: COORD_W];
                coord_b = rd_first[0 +: COORD_W];
            end
            2'd1:
            begin
                coord_a = rd_second[COORD_W +: COORD_W];
                coord_b = rd_first[COORD_W +: COORD_W];
            end
            2'd2:
            begin
                coord_a = rd_second[2*COORD_W +: COORD_W];
                coord_b = rd_first[2*COORD_W +: COORD_W];
            end
            default:
            begin
                coord_a = '0;
                coord_b = '0;
            end
        endcase
    end

    assign diff = $signed({coord_a[COORD_W-1], coord_a}) - $signed({coord_b[COORD_W-1], coord_b});

    // Select the squarer operand
    always_comb
    begin
        case (state_reg)
            S_LIMA:  mult_a = {1'b0, min_lim_reg};
            S_LIMB:  mult_a = {1'b0, max_lim_reg};
            S_SQ:    mult_a = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
            default: mult_a = '0;
        endcase
    end

    // Shared squarer, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= DIST_W'(mult_a) * DIST_W'(mult_a);
    end

    assign pair_last_j = (j_reg + CNT_W'(1)) == first_cnt_reg;
    assign pair_last_i = (i_reg + CNT_W'(1)) == second_cnt_reg;

    // Decide the verdict from the gathered results
    always_comb
    begin
        if (first_area_reg < second_area_reg)
        begin
            verdict_calc = VERDICT_LARGER;
        end
        else if (overlap_reg)
        begin
            verdict_calc = VERDICT_OVERLAP;
        end
        else if ((closest_reg > DIST_W'(lim_min_sq_reg)) || (first_cnt_reg == '0)
                 || (second_cnt_reg == '0))
        begin
            verdict_calc = VERDICT_CLOSEST;
        end
        else if (farthest_reg > DIST_W'(lim_max_sq_reg))
        begin
            verdict_calc = VERDICT_FARTHEST;
        end
        else
        begin
            verdict_calc = VERDICT_ACCEPT;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        first_cnt_next    = first_cnt_reg;
        second_cnt_next   = second_cnt_reg;
        first_area_next   = first_area_reg;
        second_area_next  = second_area_reg;
        overlap_next      = overlap_reg;
        overflow_next     = overflow_reg;
        min_lim_next      = min_lim_reg;
        max_lim_next      = max_lim_reg;
        out_valid_next    = out_valid_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        acc_next          = acc_reg;
        closest_next      = closest_reg;
        farthest_next     = farthest_reg;
        lim_min_sq_next   = lim_min_sq_reg;
        lim_max_sq_next   = lim_max_sq_reg;
        can_connect_next  = can_connect_reg;
        verdict_next      = verdict_reg;
        out_closest_next  = out_closest_reg;
        out_farthest_next = out_farthest_reg;
        dropped_next      = dropped_reg;

        // Drop the result word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Take limit writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_LIMIT: min_lim_next = cfg_data;
                CFG_MAX_LIMIT: max_lim_next = cfg_data;
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (command)
                        CMD_LOAD_FIRST:
                        begin
                            if (first_cnt_reg == CNT_FULL)
                                overflow_next = 1'b1;
                            else
                                first_cnt_next = first_cnt_reg + CNT_W'(1);
                        end
                        CMD_LOAD_SECOND:
                        begin
                            if (second_cnt_reg == CNT_FULL)
                                overflow_next = 1'b1;
                            else
                                second_cnt_next = second_cnt_reg + CNT_W'(1);
                        end
                        CMD_MASK:
                        begin
                            if (in_first_mask && (first_area_reg < AREA_FULL))
                                first_area_next = first_area_reg + AREA_W'(1);
                            if (in_second_mask && (second_area_reg < AREA_FULL))
                                second_area_next = second_area_reg + AREA_W'(1);
                            if (in_first_mask && in_second_mask)
                                overlap_next = 1'b1;
                        end
                        default:
                        begin
                            closest_next  = CLOSEST_SAT;
                            farthest_next = '0;
                            i_next        = '0;
                            j_next        = '0;
                            state_next    = S_LIMA;
                        end
                    endcase
                end
            end
            S_LIMA:
            begin
                state_next = S_LIMB;
            end
            S_LIMB:
            begin
                lim_min_sq_next = prod_reg[LIMSQ_W-1:0];
                state_next      = S_LIMC;
            end
            S_LIMC:
            begin
                lim_max_sq_next = prod_reg[LIMSQ_W-1:0];
                if ((first_cnt_reg == '0) || (second_cnt_reg == '0))
                    state_next = S_VERD;
                else
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                step_next  = 2'd0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                // Square one component per cycle, add the previous square
                case (step_reg)
                    2'd0:    acc_next = '0;
                    2'd1:    acc_next = prod_reg;
                    default: acc_next = acc_reg + prod_reg;
                endcase
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (acc_reg < closest_reg)
                    closest_next = acc_reg;
                if (acc_reg > farthest_reg)
                    farthest_next = acc_reg;
                // Advance to the next pair
                if (pair_last_j)
                begin
                    j_next = '0;
                    if (pair_last_i)
                    begin
                        state_next = S_VERD;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_ADDR;
                    end
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_ADDR;
                end
            end
            S_VERD:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    verdict_next      = verdict_calc;
                    can_connect_next  = (verdict_calc == VERDICT_ACCEPT);
                    out_closest_next  = closest_reg;
                    out_farthest_next = farthest_reg;
                    dropped_next      = overflow_reg;
                    first_cnt_next    = '0;
                    second_cnt_next   = '0;
                    first_area_next   = '0;
                    second_area_next  = '0;
                    overlap_next      = 1'b0;
                    overflow_next     = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= 2'd0;
            first_cnt_reg   <= '0;
            second_cnt_reg  <= '0;
            first_area_reg  <= '0;
            second_area_reg <= '0;
            overlap_reg     <= 1'b0;
            overflow_reg    <= 1'b0;
            min_lim_reg     <= '0;
            max_lim_reg     <= MAX_LIMIT_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            first_cnt_reg   <= first_cnt_next;
            second_cnt_reg  <= second_cnt_next;
            first_area_reg  <= first_area_next;
            second_area_reg <= second_area_next;
            overlap_reg     <= overlap_next;
            overflow_reg    <= overflow_next;
            min_lim_reg     <= min_lim_next;
            max_lim_reg     <= max_lim_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        i_reg            <= i_next;
        j_reg            <= j_next;
        acc_reg          <= acc_next;
        closest_reg      <= closest_next;
        farthest_reg     <= farthest_next;
        lim_min_sq_reg   <= lim_min_sq_next;
        lim_max_sq_reg   <= lim_max_sq_next;
        can_connect_reg  <= can_connect_next;
        verdict_reg      <= verdict_next;
        out_closest_reg  <= out_closest_next;
        out_farthest_reg <= out_farthest_next;
        dropped_reg      <= dropped_next;
    end

    assign out_valid      = out_valid_reg;
    assign can_connect    = can_connect_reg;
    assign verdict        = verdict_reg;
    assign closest_sq_mm  = out_closest_reg;
    assign farthest_sq_mm = out_farthest_reg;
    assign points_dropped = dropped_reg;

    // Point counts stay within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (first_cnt_reg <= CNT_FULL) && (second_cnt_reg <= CNT_FULL))
        else $error("point count beyond capacity");

    // Area counts saturate
    assert property (@(posedge clk) disable iff (!rst_n)
        (first_area_reg <= AREA_FULL) && (second_area_reg <= AREA_FULL))
        else $error("area count beyond saturation");

    // A result word appears only out of the verdict step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_VERD))
        else $error("result word raised outside verdict step");

    // can_connect agrees with the verdict code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (can_connect_reg == (verdict_reg == VERDICT_ACCEPT)))
        else $error("can_connect disagrees with verdict");

    // An accepted pair never has a closest distance above the farthest
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (verdict_reg == VERDICT_ACCEPT)) |->
        (out_closest_reg <= out_farthest_reg))
        else $error("accepted pair with closest above farthest");

endmodule

`default_nettype wire

### hw/rtl/oppc_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module oppc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
